// ===== design/lmsl_pkg.sv =====
// Shared constants for the longest monotone subsequence length block.
// No dependencies; the interfaces, the top level and the bench import this package.
package lmsl_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_LENGTH_DEF  = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Result length field is fixed at 11 bits (count masked to this width)
  localparam int LENGTH_W = 11;

  // Configuration channel geometry
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STRICT_MODE     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_INCREASING_MODE = CFG_INDEX_W'(1);

endpackage

// ===== design/lmsl_if.sv =====
// Valid/ready channel interfaces: input items, results and configuration writes.
// Depends on lmsl_pkg.
interface lmsl_item_if #(
  parameter int VALUE_WIDTH = lmsl_pkg::VALUE_WIDTH_DEF
);
  import lmsl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface lmsl_result_if;
  import lmsl_pkg::*;

  logic                valid;
  logic                ready;
  logic [LENGTH_W-1:0] length;
  logic                is_final;
  logic                overflow;

  modport source (output valid, length, is_final, overflow, input ready);
  modport sink   (input valid, length, is_final, overflow, output ready);
endinterface

interface lmsl_cfg_if;
  import lmsl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/lmsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/longest_monotone_subsequence_length.sv =====
// Top level: streaming longest monotone subsequence length (patience sorting).
// Depends on lmsl_pkg, the channel interfaces in lmsl_if and lmsl_ram.
// Usage
//   items   : one word per element (signed value, last flag). Accepted only
//             while the block is idle; one word is in flight at a time.
//   results : one word per element: running length, is_final (copy of last)
//             and overflow (an append was dropped this sequence, store full).
//   cfg     : register writes (strict_mode, increasing_mode), always ready;
//             unknown indexes are ignored. Write only while idle.
// Timing
//   With n tails stored a word is searched with p binary search probes
//   (0 when n = 0, at most floor(log2 n) + 1), one per cycle on the tail
//   RAM's single read port, before its result is loaded. The next word is
//   taken in the cycle after the result is loaded, so the block takes a
//   new word only once it is through with the last one.
// Reset clears the tail count, the overflow flag and the result valid flag and
// sets both modes to 1. The tail RAM is not cleared: only entries written in
// the current sequence are read. If the receiver stalls, a finished result
// holds in the output register and the next word waits for it before its
// write-back.
module longest_monotone_subsequence_length #(
  parameter int MAX_LENGTH  = lmsl_pkg::MAX_LENGTH_DEF,
  parameter int VALUE_WIDTH = lmsl_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lmsl_item_if.sink     items,
  lmsl_result_if.source results,
  lmsl_cfg_if.sink      cfg
);
  import lmsl_pkg::*;

  localparam int CW = $clog2(MAX_LENGTH + 1);  // count / bound width
  localparam int AW = $clog2(MAX_LENGTH);      // RAM address width

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE
  } state_t;

  state_t                        state;
  logic signed [VALUE_WIDTH-1:0] key;
  logic                          last_q;
  logic [CW-1:0]                 lo;
  logic [CW-1:0]                 hi;
  logic [CW-1:0]                 count;
  logic                          ovf_seen;
  logic                          strict_mode;
  logic                          increasing_mode;
  logic                          out_valid;
  logic [LENGTH_W-1:0]           out_length;
  logic                          out_final;
  logic                          out_ovf;

  logic [VALUE_WIDTH-1:0]        rd_data;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic signed [VALUE_WIDTH-1:0] tail;
  logic                          hit;
  logic [CW:0]                   sum;
  logic [CW-1:0]                 mid;
  logic [CW-1:0]                 lo_next;
  logic [CW-1:0]                 hi_next;
  logic [CW:0]                   sum_next;
  logic [CW-1:0]                 mid_next;
  logic [CW-1:0]                 count_half;
  logic                          out_free;
  logic                          full;
  logic                          appended;
  logic [CW-1:0]                 count_upd;
  logic                          ovf_upd;

  // Tail store
  lmsl_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_LENGTH)
  ) u_tails (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lo[AW-1:0]),
    .wr_data (key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare: does the probed tail meet the mode's predicate
  assign tail = signed'(rd_data);
  always_comb begin
    unique case ({increasing_mode, strict_mode})
      2'b11:   hit = (tail >= key);
      2'b10:   hit = (tail > key);
      2'b01:   hit = (tail <= key);
      default: hit = (tail < key);
    endcase
  end

  // Bound update and next probe address
  assign sum      = {1'b0, lo} + {1'b0, hi};
  assign mid      = sum[CW:1];
  assign lo_next  = hit ? lo : mid + CW'(1);
  assign hi_next  = hit ? mid : hi;
  assign sum_next = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = sum_next[CW:1];
  assign count_half = count >> 1;
  assign rd_addr  = (state == S_IDLE) ? count_half[AW-1:0] : mid_next[AW-1:0];

  // Write-back: replace at lo, append when lo reaches the count
  assign out_free  = !out_valid || results.ready;
  assign full      = (count == CW'(MAX_LENGTH));
  assign appended  = (lo == count);
  assign count_upd = (appended && !full) ? count + CW'(1) : count;
  assign ovf_upd   = ovf_seen | (appended && full);
  assign wr_en     = (state == S_WRITE) && out_free && (lo != CW'(MAX_LENGTH));

  // Sequencer, configuration registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      ovf_seen        <= 1'b0;
      out_valid       <= 1'b0;
      strict_mode     <= 1'b1;
      increasing_mode <= 1'b1;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == CFG_STRICT_MODE) begin
          strict_mode <= cfg.data[0];
        end else if (cfg.index == CFG_INCREASING_MODE) begin
          increasing_mode <= cfg.data[0];
        end
      end

      // result taken; in S_WRITE the register is reloaded instead
      if (out_valid && results.ready && (state != S_WRITE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (items.valid) begin
            key    <= items.value;
            last_q <= items.last;
            lo     <= '0;
            hi     <= count;
            state  <= (count == '0) ? S_WRITE : S_SEARCH;
          end
        end
        S_SEARCH: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_next >= hi_next) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_length <= LENGTH_W'(count_upd);
            out_final  <= last_q;
            out_ovf    <= ovf_upd;
            count      <= last_q ? '0 : count_upd;
            ovf_seen   <= last_q ? 1'b0 : ovf_upd;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign items.ready      = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign results.valid    = out_valid;
  assign results.length   = out_length;
  assign results.is_final = out_final;
  assign results.overflow = out_ovf;

`ifndef SYNTHESIS
  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LENGTH))
    else $error("tail count beyond store depth");

  // the search window is never empty while probing
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo < hi))
    else $error("binary search entered with empty window");

  // one word in flight: no acceptance in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("second word accepted while busy");

  // a final result leaves the store empty for the next sequence
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    ($rose(results.valid) && results.is_final) |-> (count == '0))
    else $error("count not cleared after last word");

  // overflow only ever reported with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.overflow) |-> (results.length == LENGTH_W'(MAX_LENGTH)))
    else $error("overflow reported with store not full");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for longest_monotone_subsequence_length: a patience-sorting
// predictor checks every result word. Depends on lmsl_pkg, lmsl_if and the top level.
module tb;
  import lmsl_pkg::*;

  localparam int MAX_LEN        = MAX_LENGTH_DEF;
  localparam int VALUE_W        = VALUE_WIDTH_DEF;
  localparam int HOLD_CYCLES    = 90;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PRINT_CAP      = 50;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    bit                        last;
  } element_t;

  typedef struct {
    logic [LENGTH_W-1:0] length;
    bit                  is_final;
    bit                  overflow;
  } lis_result_t;

  logic clk = 1'b0;
  logic rst;

  lmsl_item_if #(.VALUE_WIDTH(VALUE_W)) item_bus ();
  lmsl_result_if                        result_bus ();
  lmsl_cfg_if                           cfg_bus ();

  longest_monotone_subsequence_length #(
    .MAX_LENGTH (MAX_LEN),
    .VALUE_WIDTH(VALUE_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (item_bus),
    .results(result_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: tails kept in the order the search expects, plus modes
  logic signed [VALUE_W-1:0] tails [MAX_LEN];
  int unsigned               tail_cnt = 0;
  bit                        ovf_seen = 1'b0;
  bit                        strict_m = 1'b1;
  bit                        incr_m   = 1'b1;

  element_t    feed_q [$];
  lis_result_t awaited [$];
  element_t    in_flight;
  lis_result_t head_want;

  bit offering     = 1'b0;
  bit calm         = 1'b0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  int burst_asked  = 0;
  int burst_served = 0;
  int quiet        = 0;
  int mismatches   = 0;
  int words_out    = 0;

  // Patience insert: binary search for the first tail meeting the mode's test
  function automatic lis_result_t patience_insert(element_t e);
    int unsigned               lo;
    int unsigned               hi;
    int unsigned               mid;
    logic signed [VALUE_W-1:0] t;
    bit                        hit;
    lis_result_t               r;
    lo = 0;
    hi = tail_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      t   = tails[mid];
      if (incr_m) hit = strict_m ? (t >= e.value) : (t > e.value);
      else        hit = strict_m ? (t <= e.value) : (t < e.value);
      if (hit) hi = mid;
      else     lo = mid + 1;
    end
    if (lo < tail_cnt) begin
      tails[lo] = e.value;
    end else if (tail_cnt < MAX_LEN) begin
      tails[tail_cnt] = e.value;
      tail_cnt++;
    end else begin
      ovf_seen = 1'b1;  // store full: append dropped
    end
    r.length   = LENGTH_W'(tail_cnt);
    r.is_final = e.last;
    r.overflow = ovf_seen;
    if (e.last) begin
      tail_cnt = 0;
      ovf_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    // keep the log short if the block is badly broken
    if (mismatches <= PRINT_CAP)
      $display("%0t mismatch on result word %0d, %s: got %0d expected %0d",
               $realtime, words_out, what, got, want);
  endtask

  task automatic queue_word(logic signed [VALUE_W-1:0] v, bit lst);
    element_t e;
    e.value = v;
    e.last  = lst;
    feed_q.insert(feed_q.size(), e);
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || offering || awaited.size() != 0) @(posedge clk);
  endtask

  // Register writes back to back: both modes plus one write to an unused index
  task automatic load_modes(bit strict_b, bit incr_b);
    logic [CFG_INDEX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0]  dat [3];
    idx[0] = CFG_STRICT_MODE;
    idx[1] = CFG_INDEX_W'($urandom_range(CFG_INCREASING_MODE + 1, (1 << CFG_INDEX_W) - 1));
    idx[2] = CFG_INCREASING_MODE;
    for (int k = 0; k < 3; k++) dat[k] = CFG_DATA_W'($urandom);
    dat[0][0] = strict_b;
    dat[2][0] = incr_b;
    for (int k = 0; k < 3; k++) begin
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= dat[k];
      cfg_bus.valid <= 1'b1;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      case (idx[k])
        CFG_STRICT_MODE:     strict_m = dat[k][0];
        CFG_INCREASING_MODE: incr_m   = dat[k][0];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Driver: offers queued words, predicts each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        awaited.insert(awaited.size(), patience_insert(in_flight));
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap == 0 && feed_q.size() != 0) begin
          in_flight = feed_q.pop_front();
          item_bus.value <= in_flight.value;
          item_bus.last  <= in_flight.last;
          item_bus.valid <= 1'b1;
          offering = 1'b1;
          send_gap = draw_gap();
        end else begin
          if (send_gap > 0) send_gap--;
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result words against the oldest prediction, drives ready
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("word with nothing outstanding", int'(result_bus.length), 0);
        end else begin
          head_want = awaited.pop_front();
          if (result_bus.length !== head_want.length)
            report_mismatch("length", int'(result_bus.length), int'(head_want.length));
          if (result_bus.is_final !== head_want.is_final)
            report_mismatch("is_final", int'(result_bus.is_final),
                            int'(head_want.is_final));
          if (result_bus.overflow !== head_want.overflow)
            report_mismatch("overflow", int'(result_bus.overflow),
                            int'(head_want.overflow));
        end
        words_out++;
        recv_gap = draw_gap();
      end
      if (burst_served != burst_asked) begin
        burst_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake means the block has hung
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no handshake for %0d cycles", $realtime, quiet);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic signed [VALUE_W-1:0] dir_vals [6];
    logic signed [VALUE_W-1:0] picks [6];
    logic signed [VALUE_W-1:0] prev;
    int budget;
    int run;
    int style;

    rst              = 1'b1;
    item_bus.valid   = 1'b0;
    item_bus.value   = '0;
    item_bus.last    = 1'b0;
    result_bus.ready = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset modes (strict, increasing): equals, extremes, replace at the top
    queue_word('0, 1'b0);
    queue_word('0, 1'b0);
    queue_word(VAL_MIN, 1'b0);
    queue_word(VAL_MAX, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(VAL_MAX, 1'b0);
    queue_word(32'sh5555_5555, 1'b1);
    wait_drained();

    // Remaining three mode pairs, same short sequence each
    dir_vals = '{32'sd3, 32'sd3, VAL_MAX, VAL_MIN, -32'sd5, 32'shAAAA_AAAA};
    for (int m = 0; m < 3; m++) begin
      load_modes(m == 1, m == 0);
      for (int i = 0; i < 6; i++) queue_word(dir_vals[i], i == 5);
      wait_drained();
    end

    // Random phases: ramps of random depth, noise and extremes; a sequence that
    // runs past the end of a phase carries on under the next phase's modes
    picks = '{VAL_MIN, VAL_MAX, '0, -1, VAL_MIN + 1, VAL_MAX - 1};
    prev  = '0;
    for (int ph = 0; ph < 16; ph++) begin
      load_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      calm   = ($urandom_range(0, 3) == 0);
      budget = $urandom_range(30, 48);
      while (budget > 0) begin
        run   = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        style = $urandom_range(0, 4);
        prev  = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
                                            : VALUE_W'($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < run && budget > 0; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            prev = VALUE_W'($urandom);  // noise inside a ramp
          end else begin
            case (style)
              0:       prev = prev + $urandom_range(0, 4);
              1:       prev = prev - $urandom_range(0, 4);
              2:       prev = VALUE_W'($urandom);
              3:       prev = VALUE_W'($urandom_range(0, 8)) - 4;
              default: prev = picks[$urandom_range(0, 5)];
            endcase
          end
          queue_word(prev, i == run - 1);
          budget--;
        end
      end
      // long receiver hold-off while the sender keeps offering
      if (ph == 4) burst_asked++;
      wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
